/* sv/m3mws_pkg.sv */
`timescale 1ns / 1ps

package m3mws_pkg;

    // Field widths
    localparam int SAMPLE_W    = 17;
    localparam int TOTAL_W     = 23;
    localparam int COUNT_W     = 6;

    // Window ring depth and the widths that follow from it
    localparam int WINDOW_DEPTH = 48;
    localparam int IDX_W        = $clog2(WINDOW_DEPTH);
    localparam int LEN_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int CMP_W        = (LEN_W > COUNT_W) ? LEN_W : COUNT_W;

    // Median prefilter
    localparam int MEDIAN_TAPS = 3;
    localparam int MSLOT_W     = 2;

    // Register reset value and shortest ring length
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(21);
    localparam int                 MIN_LEN     = 2;

    // Stream data widths (whole bytes)
    localparam int IN_DATA_W  = ((SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((SAMPLE_W + TOTAL_W + 7) / 8) * 8;

endpackage

/* sv/median3_moving_window_sum.sv */
`timescale 1ns / 1ps
// Path: the input stage registers an accepted item, then the result register takes it
//   once the master side is free; a stalled result register holds the input stage.
// Throughput: one item per cycle while the master side takes results; the window ring
//   read is issued at accept and its write lands when the input stage advances, with a bypass between the two.
// Reset (synchronous, active low) and every write of sample_count clear all
//   state at once, window ring valid bits included; no clearing pass.
module median3_moving_window_sum (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration: sample_count
    input  logic                                  i_cfg_wr_en,
    input  logic [m3mws_pkg::COUNT_W-1:0]         i_cfg_wr_data,
    // slave side
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [m3mws_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // [16:0] pressure
    // master side
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [m3mws_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // [16:0] filtered_pressure,
                                                                 // [39:17] window_sum
    output logic [0:0]                            m_axis_tuser   // [0] sum_ready
);

    localparam int SW = m3mws_pkg::SAMPLE_W;
    localparam int TW = m3mws_pkg::TOTAL_W;
    localparam int IW = m3mws_pkg::IDX_W;
    localparam int LW = m3mws_pkg::LEN_W;
    localparam int CW = m3mws_pkg::CMP_W;
    localparam int MW = m3mws_pkg::MSLOT_W;
    localparam int WD = m3mws_pkg::WINDOW_DEPTH;
    localparam int OUT_PAD_W = m3mws_pkg::OUT_DATA_W;

    // Configuration and front state
    logic [m3mws_pkg::COUNT_W-1:0] r_count;
    logic [SW-1:0]                 r_med [m3mws_pkg::MEDIAN_TAPS];
    logic [MW-1:0]                 r_mslot;
    logic                          r_mfull;
    logic [IW-1:0]                 r_wslot;
    logic                          r_wfull;

    // Window ring and its valid bits
    logic [SW-1:0]                 r_win_mem [WD];
    logic [WD-1:0]                 r_win_vld;

    // Input stage
    logic                          r_s1_valid;
    logic [SW-1:0]                 r_s1_filt;
    logic [IW-1:0]                 r_s1_cur;
    logic                          r_s1_full;
    logic [SW-1:0]                 r_mem_q;
    logic                          r_s1_vldq;
    logic                          r_s1_byp;
    logic [SW-1:0]                 r_s1_bypd;

    // Running total and result register
    logic [TW-1:0]                 r_total;
    logic                          r_out_valid;
    logic [SW-1:0]                 r_out_filt;
    logic [TW-1:0]                 r_out_sum;
    logic                          r_out_ready;

    logic                          accept;
    logic                          s1_adv;
    logic [SW-1:0]                 sample;
    logic [MW-1:0]                 ms;
    logic [MW-1:0]                 ms_inc;
    logic                          m_wrap;
    logic [MW-1:0]                 n_mslot;
    logic                          n_mfull;
    logic [SW-1:0]                 ta, tb, tc;
    logic [SW-1:0]                 lo, hi, mt, med;
    logic [SW-1:0]                 filt;
    logic [CW-1:0]                 cnt_ext;
    logic [LW-1:0]                 len;
    logic [LW-1:0]                 cur_w;
    logic [LW-1:0]                 nxt_w;
    logic                          w_wrap;
    logic [IW-1:0]                 cur_idx;
    logic [IW-1:0]                 nxt_idx;
    logic [SW-1:0]                 oldest;
    logic [TW-1:0]                 n_total;

    // Handshake
    assign s1_adv        = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign sample        = s_axis_tdata[SW-1:0];

    // Median ring: place the new sample, then take the middle of three
    always_comb begin
        ms      = (r_mslot >= MW'(m3mws_pkg::MEDIAN_TAPS)) ? '0 : r_mslot;
        ms_inc  = ms + MW'(1);
        m_wrap  = (ms_inc == MW'(m3mws_pkg::MEDIAN_TAPS));
        n_mslot = m_wrap ? '0 : ms_inc;
        n_mfull = r_mfull || m_wrap;
        ta      = (ms == MW'(0)) ? sample : r_med[0];
        tb      = (ms == MW'(1)) ? sample : r_med[1];
        tc      = (ms == MW'(2)) ? sample : r_med[2];
        lo      = (ta < tb) ? ta : tb;
        hi      = (ta < tb) ? tb : ta;
        mt      = (hi < tc) ? hi : tc;
        med     = (lo > mt) ? lo : mt;
        filt    = n_mfull ? med : sample;
    end

    // Window slots: clamp the length, find this slot and the oldest one
    always_comb begin
        cnt_ext = CW'(r_count);
        if (cnt_ext < CW'(m3mws_pkg::MIN_LEN)) begin
            len = LW'(m3mws_pkg::MIN_LEN);
        end else if (cnt_ext > CW'(WD)) begin
            len = LW'(WD);
        end else begin
            len = LW'(cnt_ext);
        end
        cur_w   = (LW'(r_wslot) >= len) ? '0 : LW'(r_wslot);
        nxt_w   = cur_w + LW'(1);
        w_wrap  = (nxt_w == len);
        cur_idx = cur_w[IW-1:0];
        nxt_idx = w_wrap ? '0 : nxt_w[IW-1:0];
    end

    // Oldest entry: bypassed write, stored value, or zero when never written
    always_comb begin
        if (r_s1_byp) begin
            oldest = r_s1_bypd;
        end else if (r_s1_vldq) begin
            oldest = r_mem_q;
        end else begin
            oldest = '0;
        end
        n_total = r_total + TW'(r_s1_filt) - TW'(oldest);
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= m3mws_pkg::COUNT_RESET;
        end else if (i_cfg_wr_en) begin
            r_count <= i_cfg_wr_data;
        end
    end

    // Front state: advance on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr_en) begin
            r_mslot <= '0;
            r_mfull <= 1'b0;
            r_wslot <= '0;
            r_wfull <= 1'b0;
        end else if (accept) begin
            r_mslot <= n_mslot;
            r_mfull <= n_mfull;
            r_wslot <= nxt_idx;
            r_wfull <= r_wfull || w_wrap;
        end
    end

    // Median ring entries
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_med[0] <= ta;
            r_med[1] <= tb;
            r_med[2] <= tc;
        end
    end

    // Window ring: write from the input stage, read the oldest at accept
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_win_mem[r_s1_cur] <= r_s1_filt;
        end
        if (accept) begin
            r_mem_q <= r_win_mem[nxt_idx];
        end
    end

    // Window valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr_en) begin
            r_win_vld <= '0;
        end else if (s1_adv) begin
            r_win_vld[r_s1_cur] <= 1'b1;
        end
    end

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr_en) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_filt <= filt;
            r_s1_cur  <= cur_idx;
            r_s1_full <= r_wfull || w_wrap;
            r_s1_vldq <= r_win_vld[nxt_idx];
            r_s1_byp  <= s1_adv && (r_s1_cur == nxt_idx);
            r_s1_bypd <= r_s1_filt;
        end
    end

    // Running total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr_en) begin
            r_total <= '0;
        end else if (s1_adv) begin
            r_total <= n_total;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr_en) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_filt  <= r_s1_filt;
            r_out_sum   <= n_total;
            r_out_ready <= r_s1_full;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_PAD_W'({r_out_sum, r_out_filt});
    assign m_axis_tuser  = r_out_ready;

endmodule

/* sv/m3mws_check.sv */
`timescale 1ns / 1ps

module m3mws_check (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    input  logic [m3mws_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    input  logic [0:0]                            m_axis_tuser
);

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result shown right after reset");

    // A restart drops anything in flight
    a_cfg_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en |=> !m_axis_tvalid)
        else $error("result shown right after sample_count write");

    // A stalled item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready && !i_cfg_wr_en
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled item changed");

    // Once the window has wrapped, sum_ready stays up until a restart
    a_ready_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] && !i_cfg_wr_en
        |=> !m_axis_tvalid || m_axis_tuser[0])
        else $error("sum_ready fell without restart");

endmodule

bind median3_moving_window_sum m3mws_check u_m3mws_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_wr_en   (i_cfg_wr_en),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* sim/median3_moving_window_sum_test.sv */
`timescale 1ns / 1ps

module median3_moving_window_sum_test;

    import m3mws_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_LIMIT = 10;
    localparam logic [SAMPLE_W-1:0] PRESSURE_MAX = '1;

    typedef enum int {
        READY_ALWAYS,
        READY_MOSTLY,
        READY_RARELY,
        READY_PERIODIC
    } ready_mode_e;

    typedef struct packed {
        logic [SAMPLE_W-1:0] filtered;
        logic [TOTAL_W-1:0]  total;
        logic                ready;
    } pressure_result_t;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    logic [COUNT_W-1:0]     i_cfg_wr_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata;   // [16:0] pressure
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;   // [16:0] filtered_pressure, [39:17] window_sum
    logic [0:0]             m_axis_tuser;   // [0] sum_ready

    // Filter model state
    logic [COUNT_W-1:0]     sample_count_reg;
    logic [SAMPLE_W-1:0]    median_taps [MEDIAN_TAPS];
    int                     median_pos;
    logic                   median_primed;
    logic [SAMPLE_W-1:0]    window_vals [WINDOW_DEPTH];
    int                     window_pos;
    logic [TOTAL_W-1:0]     window_total;
    logic                   window_wrapped;

    pressure_result_t       expected_results [$];
    int                     error_count = 0;
    int                     hold_request = 0;
    int                     cycle_count;

    median3_moving_window_sum DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Clear all filter state and keep the given ring length
    function automatic void restart_filter(input logic [COUNT_W-1:0] count);
        sample_count_reg = count;
        median_pos = 0;
        median_primed = 1'b0;
        foreach (window_vals[k]) window_vals[k] = '0;
        window_pos = 0;
        window_total = '0;
        window_wrapped = 1'b0;
    endfunction

    function automatic logic [SAMPLE_W-1:0] middle_of(input logic [SAMPLE_W-1:0] a,
                                                      input logic [SAMPLE_W-1:0] b,
                                                      input logic [SAMPLE_W-1:0] c);
        logic [SAMPLE_W-1:0] lo;
        logic [SAMPLE_W-1:0] hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c < lo) return lo;
        if (c > hi) return hi;
        return c;
    endfunction

    // Advance median stage and window total by one sample
    function automatic pressure_result_t filter_sample(input logic [SAMPLE_W-1:0] sample);
        int                  ring_len;
        int                  cur;
        int                  nxt;
        logic [SAMPLE_W-1:0] filt;
        ring_len = sample_count_reg;
        if (ring_len < MIN_LEN) ring_len = MIN_LEN;
        if (ring_len > WINDOW_DEPTH) ring_len = WINDOW_DEPTH;

        median_taps[median_pos] = sample;
        median_pos++;
        if (median_pos == MEDIAN_TAPS) begin
            median_pos = 0;
            median_primed = 1'b1;
        end
        filt = median_primed ? middle_of(median_taps[0], median_taps[1], median_taps[2])
                             : sample;

        cur = (window_pos >= ring_len) ? 0 : window_pos;
        nxt = cur + 1;
        if (nxt == ring_len) begin
            nxt = 0;
            window_wrapped = 1'b1;
        end
        window_vals[cur] = filt;
        window_total = window_total + TOTAL_W'(filt) - TOTAL_W'(window_vals[nxt]);
        window_pos = nxt;
        return '{filt, window_total, window_wrapped};
    endfunction

    // Check each result, then predict each accepted item
    always @(posedge i_clk) begin : monitor
        pressure_result_t got;
        pressure_result_t want;
        if (!i_rst_n) begin
            restart_filter(COUNT_RESET);
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tdata[SAMPLE_W-1:0],
                        m_axis_tdata[SAMPLE_W+TOTAL_W-1:SAMPLE_W], m_axis_tuser[0]};
                if (expected_results.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("%0t: result with none expected: filt=%0d sum=%0d ready=%0b",
                                 $realtime, got.filtered, got.total, got.ready);
                end else begin
                    want = expected_results.pop_front();
                    if (got.filtered !== want.filtered || got.total !== want.total ||
                        got.ready !== want.ready) begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                            $display("%0t: mismatch: filt %0d/%0d sum %0d/%0d ready %0b/%0b %s",
                                     $realtime, want.filtered, got.filtered, want.total,
                                     got.total, want.ready, got.ready, "(expected/actual)");
                    end
                end
            end
            if (i_cfg_wr_en)
                restart_filter(i_cfg_wr_data);
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(filter_sample(s_axis_tdata[SAMPLE_W-1:0]));
        end
    end

    // Stall the output side on a changing pattern; honor long hold requests
    initial begin : receiver
        ready_mode_e mode;
        int          mode_left;
        int          hold_left;
        int          beat;
        mode = READY_ALWAYS;
        mode_left = 0;
        hold_left = 0;
        beat = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (mode_left == 0) begin
                mode = ready_mode_e'($urandom_range(0, 3));
                mode_left = $urandom_range(40, 300);
            end
            mode_left--;
            beat++;
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case (mode)
                    READY_ALWAYS:   m_axis_tready <= 1'b1;
                    READY_MOSTLY:   m_axis_tready <= ($urandom_range(0, 9) < 8);
                    READY_RARELY:   m_axis_tready <= ($urandom_range(0, 9) < 3);
                    READY_PERIODIC: m_axis_tready <= ((beat % 4) != 3);
                    default:        m_axis_tready <= 1'b1;
                endcase
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Offer one item and wait until it is taken
    task automatic send_pressure(input logic [SAMPLE_W-1:0] pressure);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'(pressure);
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic pause_sender(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= IN_DATA_W'($urandom_range(0, PRESSURE_MAX));
        end
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // Write the ring length once the block has gone idle
    task automatic write_sample_count(input logic [COUNT_W-1:0] count);
        pause_sender(1);
        wait_drained();
        repeat (4) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= count;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_pressure(input logic [SAMPLE_W-1:0] prev);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return PRESSURE_MAX;
            2:       return prev;
            3:       return SAMPLE_W'($urandom_range(0, 15));
            4:       return PRESSURE_MAX - SAMPLE_W'($urandom_range(0, 15));
            5, 6:    return prev + SAMPLE_W'($urandom_range(0, 64)) - SAMPLE_W'(32);
            default: return SAMPLE_W'($urandom_range(0, PRESSURE_MAX));
        endcase
    endfunction

    // Send a run of random samples in bursts with random gaps
    task automatic send_random_run(input int n_items, input bit no_gaps);
        int                  burst;
        logic [SAMPLE_W-1:0] prev;
        prev = SAMPLE_W'($urandom_range(0, PRESSURE_MAX));
        while (n_items > 0) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && n_items > 0) begin
                prev = pick_pressure(prev);
                send_pressure(prev);
                burst--;
                n_items--;
            end
            if (!no_gaps && $urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 8));
        end
    endtask

    // Raw samples before the median fills, then medians of extremes
    task automatic test_median_startup();
        send_pressure('0);
        send_pressure(PRESSURE_MAX);
        send_pressure(17'h15555);
        send_pressure(17'h0AAAA);
        send_pressure(PRESSURE_MAX);
        send_pressure('0);
        send_pressure(PRESSURE_MAX);
    endtask

    // Lengths below the minimum act as the shortest ring
    task automatic test_short_window();
        write_sample_count('0);
        send_pressure(PRESSURE_MAX);
        send_pressure('0);
        send_pressure(PRESSURE_MAX);
        send_pressure(17'd5);
        write_sample_count(COUNT_W'(1));
        send_pressure(17'd100);
        send_pressure(PRESSURE_MAX);
        send_pressure(17'd7);
        write_sample_count(COUNT_W'(MIN_LEN));
        send_pressure(PRESSURE_MAX);
        send_pressure(PRESSURE_MAX);
        send_pressure(PRESSURE_MAX);
        send_pressure('0);
    endtask

    // Walk through ring lengths, extremes and out-of-range values included
    task automatic test_random_settings();
        logic [COUNT_W-1:0] counts [12];
        counts = '{COUNT_W'(2), COUNT_W'(48), COUNT_W'(0), '1, COUNT_W'(3), COUNT_W'(1),
                   COUNT_W'(49), COUNT_W'($urandom_range(2, 48)),
                   COUNT_W'($urandom_range(0, 63)), COUNT_RESET, COUNT_W'(47),
                   COUNT_W'($urandom_range(2, 48))};
        foreach (counts[k]) begin
            write_sample_count(counts[k]);
            send_random_run($urandom_range(120, 160), ($urandom_range(0, 4) == 0));
        end
    endtask

    // Hold the output side off while items keep coming
    task automatic test_output_backpressure();
        write_sample_count(COUNT_W'(WINDOW_DEPTH));
        hold_request = 400;
        send_random_run(120, 1'b1);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_median_startup();
        test_short_window();
        test_random_settings();
        test_output_backpressure();

        pause_sender(1);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
sv/m3mws_pkg.sv
sv/median3_moving_window_sum.sv
sv/m3mws_check.sv
sim/median3_moving_window_sum_test.sv
